/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the ring FIFO checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/rfb_pkg.sv */
// ----------------------------------------------------------------------------
// rfb_pkg
// Types, sizes and codes shared by the ring FIFO batch push/pop block.
// ----------------------------------------------------------------------------
`default_nettype none

package rfb_pkg;

    localparam int CAPACITY    = 1024;
    localparam int MAX_POP_RUN = 64;

    localparam int AW      = $clog2(CAPACITY);
    localparam int CW      = $clog2(MAX_POP_RUN + 1);
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 7;
    localparam int RUN_W   = 10;
    localparam int LEVEL_W = 10;

    localparam logic [RUN_W-1:0] BATCH_MAX = {RUN_W{1'b1}};

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] value;
        logic                     batch_end;
        logic [CNT_W-1:0]         max_count;
    } t_in;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] data;
        logic [RUN_W-1:0]         run_count;
        logic                     last;
        logic [LEVEL_W-1:0]       level;
    } t_out;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic push;
        logic pop_empty;
        logic pop_start;
        logic pop_emit;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic is_push;
        logic pop_zero;
        logic run_last;
    } t_stat;

endpackage

`default_nettype wire

/* design/rfb_ram.sv */
// ----------------------------------------------------------------------------
// rfb_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* design/rfb_ctrl.sv */
// ----------------------------------------------------------------------------
// rfb_ctrl
// Sequencer: accepts items and steps through the words of a pop run.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire rfb_pkg::t_stat i_stat,
    output rfb_pkg::t_cmd      o_cmd,
    output logic               o_in_stall
);

    rfb_pkg::t_state r_state;
    rfb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            rfb_pkg::ST_IDLE: begin
                o_in_stall = !i_stat.slot_free;
                if (i_in_valid && i_stat.slot_free) begin
                    if (i_stat.is_push) begin
                        o_cmd.push = 1'b1;
                    end else if (i_stat.pop_zero) begin
                        o_cmd.pop_empty = 1'b1;
                    end else begin
                        o_cmd.pop_start = 1'b1;
                        n_state         = rfb_pkg::ST_EMIT;
                    end
                end
            end
            rfb_pkg::ST_EMIT: begin
                if (i_stat.slot_free) begin
                    o_cmd.pop_emit = 1'b1;
                    if (i_stat.run_last) begin
                        n_state = rfb_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = rfb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/rfb_dp.sv */
// ----------------------------------------------------------------------------
// rfb_dp
// Datapath: ring indices, batch counter, word store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rfb_pkg::t_in  i_in,
    input  wire rfb_pkg::t_cmd i_cmd,
    output rfb_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output rfb_pkg::t_out      o_out,
    input  wire logic          i_out_stall
);

    localparam int AW    = rfb_pkg::AW;
    localparam int CW    = rfb_pkg::CW;
    localparam int CMP_W = (AW > CW) ? AW : CW;

    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [rfb_pkg::RUN_W-1:0] r_batch, n_batch;
    logic [CW-1:0] r_run_n, n_run_n;
    logic [CW-1:0] r_k, n_k;
    logic          r_out_valid, n_out_valid;
    rfb_pkg::t_out r_out, n_out;

    logic [AW-1:0] level_now;
    logic [AW:0]   level_wide;
    logic          full;
    logic [AW-1:0] rd_next;
    logic [AW-1:0] wr_next;
    logic [CW-1:0] cap_cnt;
    logic [CW-1:0] run_n_calc;
    logic [CW-1:0] k_inc;
    logic [rfb_pkg::RUN_W-1:0] batch_inc;
    logic          push_ok;
    logic          slot_free;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [rfb_pkg::DATA_W-1:0] ram_rdata;

    // Occupancy from the two indices, wrapping modulo the capacity.
    assign level_wide = {1'b0, r_wr_idx} + (AW + 1)'(rfb_pkg::CAPACITY) - {1'b0, r_rd_idx};
    assign level_now  = (r_wr_idx >= r_rd_idx) ? (r_wr_idx - r_rd_idx) : level_wide[AW-1:0];
    assign full       = (level_now == AW'(rfb_pkg::CAPACITY - 1));

    assign rd_next = (r_rd_idx == AW'(rfb_pkg::CAPACITY - 1)) ? '0 : r_rd_idx + AW'(1);
    assign wr_next = (r_wr_idx == AW'(rfb_pkg::CAPACITY - 1)) ? '0 : r_wr_idx + AW'(1);

    assign cap_cnt = (i_in.max_count > rfb_pkg::CNT_W'(rfb_pkg::MAX_POP_RUN))
                   ? CW'(rfb_pkg::MAX_POP_RUN) : CW'(i_in.max_count);
    assign run_n_calc = (CMP_W'(cap_cnt) > CMP_W'(level_now)) ? CW'(level_now) : cap_cnt;

    assign k_inc     = r_k + CW'(1);
    assign push_ok   = !full;
    assign batch_inc = (r_batch < rfb_pkg::BATCH_MAX) ? r_batch + rfb_pkg::RUN_W'(1) : r_batch;
    assign slot_free = !r_out_valid || !i_out_stall;

    assign o_stat.slot_free = slot_free;
    assign o_stat.is_push   = (i_in.op == rfb_pkg::OP_PUSH);
    assign o_stat.pop_zero  = (run_n_calc == '0);
    assign o_stat.run_last  = (k_inc == r_run_n);

    assign ram_we    = i_cmd.push && push_ok;
    assign ram_re    = i_cmd.pop_start || (i_cmd.pop_emit && !o_stat.run_last);
    assign ram_raddr = i_cmd.pop_start ? r_rd_idx : rd_next;

    rfb_ram #(
        .WIDTH (rfb_pkg::DATA_W),
        .DEPTH (rfb_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_idx),
        .i_wdata (i_in.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_rd_idx    = r_rd_idx;
        n_wr_idx    = r_wr_idx;
        n_batch     = r_batch;
        n_run_n     = r_run_n;
        n_k         = r_k;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cmd.push) begin
            n_out_valid     = 1'b1;
            n_out.ok        = push_ok;
            n_out.data      = '0;
            n_out.last      = 1'b1;
            n_out.run_count = push_ok ? batch_inc : r_batch;
            n_out.level     = rfb_pkg::LEVEL_W'(level_now + AW'(push_ok));
            if (push_ok) begin
                n_wr_idx = wr_next;
            end
            if (i_in.batch_end) begin
                n_batch = '0;
            end else if (push_ok) begin
                n_batch = batch_inc;
            end
        end

        if (i_cmd.pop_empty) begin
            n_out_valid     = 1'b1;
            n_out.ok        = 1'b0;
            n_out.data      = '0;
            n_out.last      = 1'b1;
            n_out.run_count = '0;
            n_out.level     = rfb_pkg::LEVEL_W'(level_now);
        end

        if (i_cmd.pop_start) begin
            n_run_n = run_n_calc;
            n_k     = '0;
        end

        if (i_cmd.pop_emit) begin
            n_out_valid     = 1'b1;
            n_out.ok        = 1'b1;
            n_out.data      = ram_rdata;
            n_out.last      = o_stat.run_last;
            n_out.run_count = rfb_pkg::RUN_W'(k_inc);
            n_out.level     = rfb_pkg::LEVEL_W'(level_now - AW'(1));
            n_rd_idx        = rd_next;
            n_k             = k_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_batch     <= '0;
            r_k         <= '0;
            r_run_n     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_batch     <= n_batch;
            r_k         <= n_k;
            r_run_n     <= n_run_n;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

/* design/ring_fifo_batch_push_pop_core.sv */
// ----------------------------------------------------------------------------
// ring_fifo_batch_push_pop_core
// Circular FIFO of signed words with batched push and run-length pop.
// ----------------------------------------------------------------------------
// The input channel carries one item per handshake: a push of one word or a
// pop of up to max_count words. The output channel carries result items from
// a single output register. A push yields one result and a pop yields one
// result per word removed, or one empty result when nothing can be removed.
// A push is taken every cycle while the output register drains, and its
// result appears in the cycle after acceptance. A pop first reads the word
// store, whose read port is registered; then, whenever the output register
// has room, one word is loaded into it while the next read is issued. The
// first word passes through the read register and then the output register,
// and the input stays stalled until the last word is loaded. An empty pop
// behaves like a push for timing. When the receiver stalls, the output
// register holds its item and the block waits, so nothing is lost.
// Reset clears the indices, the batch counter and the output valid flag. The
// word store is not cleared and needs no clearing pass, since no entry is read
// before it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_batch_push_pop_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire rfb_pkg::t_in i_in,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output rfb_pkg::t_out     o_out
);

    // Commands flow from the sequencer to the datapath, status flows back.
    rfb_pkg::t_cmd  cmd;
    rfb_pkg::t_stat stat;

    rfb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath owns the store, the indices and the result register.
    rfb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

/* design/rfb_checker.sv */
// ----------------------------------------------------------------------------
// rfb_checker
// Port-level checks for the ring FIFO block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rfb_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_in_stall,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire rfb_pkg::t_out o_out
);

    // A stalled result item stays in place.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))

    // An item without a word carries zero data.
    `ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, o_out_valid && !o_out.ok, o_out.data == '0)

    // Refused push results and empty pop results are always final.
    `ASSERT_IMPLY(a_empty_last, i_clk, i_rst_n, o_out_valid && !o_out.ok, o_out.last)

    // While a pop run still has words to deliver, no new item is taken.
    `ASSERT_IMPLY(a_run_blocks, i_clk, i_rst_n, o_out_valid && !o_out.last, o_in_stall)

endmodule

bind ring_fifo_batch_push_pop_core rfb_checker u_rfb_checker (.*);

`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring FIFO with batched push and run-length pop.
// ----------------------------------------------------------------------------
// A mirror of the queue is updated on every accepted input item. It produces
// the result items that the block must return, in order. A monitor compares
// every accepted result with the oldest one still due, field by field. The
// run goes through directed corner cases, a long receiver hold-off and random
// traffic under three idling schemes.
// ----------------------------------------------------------------------------

module tb_top;

    // Clock, reset and the two channels. Every input of the block starts at a
    // known value so that nothing is undefined before reset is released.
    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    rfb_pkg::t_in  in_item  = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    rfb_pkg::t_out out_item;

    always #5 clk = ~clk;

    ring_fifo_batch_push_pop_core DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    // Mirror of the queue. The word store is only ever read at indices that
    // have been written, so it needs no reset value.
    logic signed [rfb_pkg::DATA_W-1:0] mirror_words [rfb_pkg::CAPACITY];
    int unsigned                       mirror_rd    = 0;
    int unsigned                       mirror_wr    = 0;
    logic [rfb_pkg::RUN_W-1:0]         mirror_batch = '0;

    // Result items that the block still owes, oldest first.
    rfb_pkg::t_out results_due[$];

    // Idling percentages for each side and the receiver's hold-off counter.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_cycles   = 0;

    // Run statistics and the failure count.
    int unsigned fail_count      = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned capped_pops     = 0;
    int unsigned empty_pops      = 0;

    rfb_pkg::t_out got_item;
    rfb_pkg::t_out due_item;

    function automatic int unsigned mirror_level();
        return (mirror_wr + rfb_pkg::CAPACITY - mirror_rd) % rfb_pkg::CAPACITY;
    endfunction

    function automatic int unsigned slot_after(input int unsigned idx);
        return (idx + 1 >= rfb_pkg::CAPACITY) ? 0 : idx + 1;
    endfunction

    // Applies one accepted input item to the mirror and queues the result
    // items it causes. A push always gives one result. A pop gives one result
    // per word removed, or a single empty result when nothing can be removed.
    function automatic void apply_fifo_item(input rfb_pkg::t_in item);
        rfb_pkg::t_out res;
        int unsigned   run_len;
        int unsigned   k;
        if (item.op == rfb_pkg::OP_PUSH) begin
            res = '0;
            if (slot_after(mirror_wr) != mirror_rd) begin
                mirror_words[mirror_wr] = item.value;
                mirror_wr = slot_after(mirror_wr);
                res.ok = 1'b1;
                if (mirror_batch != rfb_pkg::BATCH_MAX) begin
                    mirror_batch = mirror_batch + 1'b1;
                end
            end
            res.run_count = mirror_batch;
            res.last      = 1'b1;
            res.level     = rfb_pkg::LEVEL_W'(mirror_level());
            results_due.push_back(res);
            if (item.batch_end) begin
                mirror_batch = '0;
            end
        end else begin
            run_len = item.max_count;
            if (run_len > rfb_pkg::MAX_POP_RUN) begin
                run_len = rfb_pkg::MAX_POP_RUN;
                if (mirror_level() >= rfb_pkg::MAX_POP_RUN) begin
                    capped_pops++;
                end
            end
            if (run_len > mirror_level()) begin
                run_len = mirror_level();
            end
            if (run_len == 0) begin
                res       = '0;
                res.last  = 1'b1;
                res.level = rfb_pkg::LEVEL_W'(mirror_level());
                results_due.push_back(res);
                empty_pops++;
            end else begin
                for (k = 0; k < run_len; k++) begin
                    res           = '0;
                    res.ok        = 1'b1;
                    res.data      = mirror_words[mirror_rd];
                    mirror_rd     = slot_after(mirror_rd);
                    res.run_count = rfb_pkg::RUN_W'(k + 1);
                    res.last      = (k + 1 == run_len);
                    res.level     = rfb_pkg::LEVEL_W'(mirror_level());
                    results_due.push_back(res);
                end
            end
        end
    endfunction

    function automatic rfb_pkg::t_in push_item(
        input logic signed [rfb_pkg::DATA_W-1:0] value,
        input logic batch_end);
        rfb_pkg::t_in item;
        item           = '0;
        item.op        = rfb_pkg::OP_PUSH;
        item.value     = value;
        item.batch_end = batch_end;
        item.max_count = rfb_pkg::CNT_W'($urandom);
        return item;
    endfunction

    function automatic rfb_pkg::t_in pop_item(input int unsigned count);
        rfb_pkg::t_in item;
        item           = '0;
        item.op        = rfb_pkg::OP_POP;
        item.value     = $urandom;
        item.batch_end = 1'($urandom);
        item.max_count = rfb_pkg::CNT_W'(count);
        return item;
    endfunction

    // Receiver: a hold-off, when one is pending, takes priority over the
    // random stalls. The counter runs here so the sender keeps offering items
    // while the receiver is held.
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Result monitor. The stall is driven at the falling edge, so at the rising
    // edge both sides see the same handshake.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got_item = out_item;
            results_checked++;
            if (results_due.size() == 0) begin
                $error("result item with nothing due: ok=%0d data=%0d run=%0d last=%0d lvl=%0d",
                       got_item.ok, got_item.data, got_item.run_count, got_item.last,
                       got_item.level);
                fail_count++;
            end else begin
                due_item = results_due.pop_front();
                if (got_item.ok !== due_item.ok) begin
                    $error("field ok: expected %0d, actual %0d", due_item.ok, got_item.ok);
                    fail_count++;
                end
                if (got_item.data !== due_item.data) begin
                    $error("field data: expected %0d, actual %0d", due_item.data,
                           got_item.data);
                    fail_count++;
                end
                if (got_item.run_count !== due_item.run_count) begin
                    $error("field run_count: expected %0d, actual %0d", due_item.run_count,
                           got_item.run_count);
                    fail_count++;
                end
                if (got_item.last !== due_item.last) begin
                    $error("field last: expected %0d, actual %0d", due_item.last,
                           got_item.last);
                    fail_count++;
                end
                if (got_item.level !== due_item.level) begin
                    $error("field level: expected %0d, actual %0d", due_item.level,
                           got_item.level);
                    fail_count++;
                end
            end
        end
    end

    // Offers one item and returns right after the edge that accepts it. Valid
    // stays high between back-to-back items; it drops only when the sender
    // decides to idle, so it gets a single assignment per falling edge.
    task automatic send_item(input rfb_pkg::t_in item);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        apply_fifo_item(item);
        items_sent++;
    endtask

    // Stops offering items and waits until every result due has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_due.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Corner cases: pops on an empty queue, the extremes of the word, a batch
    // closed mid-stream, a zero-count pop with data present, and a pop count
    // beyond what the queue holds.
    task automatic test_directed();
        send_item(pop_item(5));
        send_item(pop_item(0));
        send_item(push_item(32'sh8000_0000, 1'b0));
        send_item(push_item(32'sh7fff_ffff, 1'b0));
        send_item(push_item(32'sh0000_0000, 1'b0));
        send_item(push_item(-32'sd1, 1'b1));
        send_item(push_item(32'sh5555_5555, 1'b1));
        send_item(pop_item(0));
        send_item(pop_item(1));
        send_item(pop_item(2));
        send_item(push_item(32'shaaaa_aaaa, 1'b0));
        send_item(pop_item(127));
        send_item(pop_item(64));
    endtask

    // The receiver is held for a long stretch while pushes and a pop keep
    // coming, so the output register fills and the input stalls. Afterwards
    // the sender pauses until everything has drained, then sends a few more.
    task automatic test_backpressure();
        int unsigned k;
        hold_cycles = 200;
        for (k = 0; k < 30; k++) begin
            send_item(push_item($urandom, (k % 10) == 9));
        end
        send_item(pop_item(25));
        wait_drained();
        send_item(pop_item(10));
        send_item(push_item($urandom, 1'b1));
        send_item(pop_item(3));
    endtask

    // Mixed traffic. Pushes slightly outnumber pops; most pops are short, some
    // ask for nothing and some ask for more than the run limit.
    task automatic test_random_traffic(input int unsigned count);
        int unsigned k;
        int unsigned pick;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < 55) begin
                send_item(push_item($urandom, $urandom_range(0, 3) == 0));
            end else begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    send_item(pop_item(0));
                end else if (pick <= 6) begin
                    send_item(pop_item($urandom_range(1, 12)));
                end else if (pick <= 8) begin
                    send_item(pop_item($urandom_range(13, 64)));
                end else begin
                    send_item(pop_item($urandom_range(65, 127)));
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender idles rarely while the receiver stalls most of the time.
        send_idle_pct = 19;
        recv_idle_pct = 77;
        test_directed();
        test_random_traffic(28);

        // The other way round: a slow sender and a mostly ready receiver.
        send_idle_pct = 77;
        recv_idle_pct = 19;
        test_random_traffic(28);

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_traffic(28);

        // Once every result due has come back nothing more may appear, so a
        // short quiet stretch is enough to catch any stray result.
        wait_drained();
        repeat (12) @(posedge clk);

        $display("Covered %0d input items and %0d result items under three idling schemes,",
                 items_sent, results_checked);
        $display("including a long receiver hold-off, %0d capped pops and %0d empty pops.",
                 capped_pops, empty_pops);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // A correct run takes well under a tenth of this.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
